// File: sv/bpdq_pkg.sv
// Shared types and constants of the buffer pool descriptor queue.
`default_nettype none

package bpdq_pkg;

   localparam int LEN_W = 16;
   localparam int IDX_W = 6;
   localparam int CNT_W = 7;
   localparam int ST_W  = 3;
   localparam int CMD_W = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH    = 2'd0,
      CMD_POP     = 2'd1,
      CMD_RELEASE = 2'd2,
      CMD_FLUSH   = 2'd3
   } cmd_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK      = 3'd0,
      ST_BAD_LEN = 3'd1,
      ST_NO_FREE = 3'd2,
      ST_EMPTY   = 3'd3,
      ST_BAD_REL = 3'd4
   } status_type;

   // Free stack controls from the sequencer
   typedef struct packed {
      logic rd;
      logic take;
      logic put;
   } stk_ctl_type;

endpackage

`default_nettype wire

// File: sv/bpdq_if.sv
// Request, response and register-write channel interfaces.
`default_nettype none

interface bpdq_req_if;
   logic                        valid;
   logic                        ready;
   logic [bpdq_pkg::CMD_W-1:0]  command;
   logic [bpdq_pkg::LEN_W-1:0]  length;
   logic [bpdq_pkg::IDX_W-1:0]  buffer_index;

   modport source (output valid, command, length, buffer_index, input ready);
   modport sink (input valid, command, length, buffer_index, output ready);
endinterface

interface bpdq_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [bpdq_pkg::ST_W-1:0]   status;
   logic [bpdq_pkg::IDX_W-1:0]  granted_index;
   logic [bpdq_pkg::LEN_W-1:0]  granted_length;
   logic [bpdq_pkg::CNT_W-1:0]  queued_count;
   logic                        is_full;
   logic                        is_empty;

   modport source (output valid, status, granted_index, granted_length, queued_count,
                   is_full, is_empty, input ready);
   modport sink (input valid, status, granted_index, granted_length, queued_count,
                 is_full, is_empty, output ready);
endinterface

interface bpdq_csr_if;
   logic                        valid;
   logic                        ready;
   logic [bpdq_pkg::LEN_W-1:0]  data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// File: sv/bpdq_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none

module bpdq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: sv/bpdq_free_stack.sv
// Free buffer index stack: RAM, fill count and low-water mark for reset contents.
`default_nettype none

module bpdq_free_stack #(
   parameter int QUEUE_DEPTH = 64
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire bpdq_pkg::stk_ctl_type              ctl,
   input  wire logic [$clog2(QUEUE_DEPTH)-1:0]     put_data,
   output logic      [$clog2(QUEUE_DEPTH)-1:0]     top_data,
   output logic      [$clog2(QUEUE_DEPTH+1)-1:0]   count
);

   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C  = CW'(QUEUE_DEPTH);
   localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] low_ff, low_in;
   logic [IW-1:0] rd_addr_ff, rd_addr_in;
   logic [IW-1:0] rd_addr;
   logic [IW-1:0] ram_q;
   logic          wr_en;
   logic [CW-1:0] count_dec;

   assign rd_addr   = IW'(count_ff - CW'(1));
   assign count_dec = count_ff - CW'(1);
   assign wr_en     = ctl.put && (count_ff != DEPTH_C);

   // Advance the fill count and track the lowest count ever reached
   always_comb begin
      count_in   = count_ff;
      low_in     = low_ff;
      rd_addr_in = rd_addr_ff;
      if (ctl.rd) begin
         rd_addr_in = rd_addr;
      end
      if (ctl.take) begin
         count_in = count_dec;
         if (count_dec < low_ff) begin
            low_in = count_dec;
         end
      end else if (wr_en) begin
         count_in = count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= DEPTH_C;
         low_ff   <= DEPTH_C;
      end else begin
         count_ff <= count_in;
         low_ff   <= low_in;
      end
      rd_addr_ff <= rd_addr_in;
   end

   bpdq_ram #(
      .WIDTH (IW),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (IW'(count_ff)),
      .wr_data (put_data),
      .rd_en   (ctl.rd),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // Entries below the low-water mark were never rewritten: hold reset contents
   assign top_data = (CW'(rd_addr_ff) >= low_ff) ? ram_q : (LAST_IDX - rd_addr_ff);
   assign count    = count_ff;

endmodule

`default_nettype wire

// File: sv/bpdq_ctrl.sv
// Command sequencer: descriptor ring pointers, flush walk and response register.
`default_nettype none

module bpdq_ctrl #(
   parameter int QUEUE_DEPTH = 64
) (
   input  wire logic                                          clock,
   input  wire logic                                          reset,
   bpdq_req_if.sink                                           req,
   bpdq_rsp_if.source                                         rsp,
   bpdq_csr_if.sink                                           csr,
   output bpdq_pkg::stk_ctl_type                              stk_ctl,
   output logic [$clog2(QUEUE_DEPTH)-1:0]                     stk_put_data,
   input  wire logic [$clog2(QUEUE_DEPTH)-1:0]                stk_top,
   input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0]              stk_count,
   output logic                                               ring_rd_en,
   output logic [$clog2(QUEUE_DEPTH)-1:0]                     ring_rd_addr,
   input  wire logic [bpdq_pkg::LEN_W+$clog2(QUEUE_DEPTH)-1:0] ring_rd_data,
   output logic                                               ring_wr_en,
   output logic [$clog2(QUEUE_DEPTH)-1:0]                     ring_wr_addr,
   output logic [bpdq_pkg::LEN_W+$clog2(QUEUE_DEPTH)-1:0]     ring_wr_data
);

   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int LW = bpdq_pkg::LEN_W;
   localparam logic [CW-1:0] DEPTH_C  = CW'(QUEUE_DEPTH);
   localparam logic [IW-1:0] LAST_PTR = IW'(QUEUE_DEPTH - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_FLUSH
   } state_type;

   state_type                   state_ff, state_in;
   bpdq_pkg::cmd_type           cmd_ff, cmd_in;
   logic [LW-1:0]               len_ff, len_in;
   logic [bpdq_pkg::IDX_W-1:0]  bidx_ff, bidx_in;
   logic [IW-1:0]               head_ff, head_in;
   logic [IW-1:0]               tail_ff, tail_in;
   logic [CW-1:0]               occ_ff, occ_in;
   logic [LW-1:0]               max_len_ff, max_len_in;
   logic                        pend_ff, pend_in;
   logic                        bad_ff, bad_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   bpdq_pkg::status_type        rsp_status_ff, rsp_status_in;
   logic [IW-1:0]               rsp_idx_ff, rsp_idx_in;
   logic [LW-1:0]               rsp_len_ff, rsp_len_in;
   logic [CW-1:0]               rsp_occ_ff, rsp_occ_in;

   logic          req_fire;
   logic          out_free;
   logic          bidx_bad;
   logic [IW-1:0] head_nxt;
   logic [IW-1:0] tail_nxt;

   assign req.ready = (state_ff == S_IDLE) && !reset;
   assign csr.ready = !reset;
   assign req_fire  = req.valid && req.ready;
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign bidx_bad  = (32'(bidx_ff) >= 32'(QUEUE_DEPTH));
   assign head_nxt  = (head_ff == LAST_PTR) ? '0 : head_ff + IW'(1);
   assign tail_nxt  = (tail_ff == LAST_PTR) ? '0 : tail_ff + IW'(1);

   assign ring_rd_addr = head_ff;
   assign ring_wr_addr = tail_ff;
   assign ring_wr_data = {len_ff, stk_top};
   assign stk_put_data = (state_ff == S_FLUSH) ? ring_rd_data[IW-1:0] : IW'(bidx_ff);

   // Sequence one request at a time
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      len_in        = len_ff;
      bidx_in       = bidx_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      occ_in        = occ_ff;
      max_len_in    = max_len_ff;
      pend_in       = pend_ff;
      bad_in        = bad_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_occ_in    = rsp_occ_ff;
      stk_ctl       = '0;
      ring_rd_en    = 1'b0;
      ring_wr_en    = 1'b0;

      if (csr.valid) begin
         max_len_in = csr.data;
      end

      unique case (state_ff)
         S_IDLE: begin
            // Latch the request and start both memory reads
            if (req_fire) begin
               cmd_in     = bpdq_pkg::cmd_type'(req.command);
               len_in     = req.length;
               bidx_in    = req.buffer_index;
               pend_in    = 1'b0;
               bad_in     = 1'b0;
               ring_rd_en = 1'b1;
               stk_ctl.rd = 1'b1;
               state_in   = (bpdq_pkg::cmd_type'(req.command) == bpdq_pkg::CMD_FLUSH)
                            ? S_FLUSH : S_EXEC;
            end
         end
         S_EXEC: begin
            // Commit once the response register is free
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = bpdq_pkg::ST_OK;
               rsp_idx_in    = '0;
               rsp_len_in    = '0;
               state_in      = S_IDLE;
               unique case (cmd_ff)
                  bpdq_pkg::CMD_PUSH: begin
                     if (len_ff == '0 || len_ff > max_len_ff) begin
                        rsp_status_in = bpdq_pkg::ST_BAD_LEN;
                     end else if (stk_count == '0 || occ_ff == DEPTH_C) begin
                        rsp_status_in = bpdq_pkg::ST_NO_FREE;
                     end else begin
                        stk_ctl.take = 1'b1;
                        ring_wr_en   = 1'b1;
                        tail_in      = tail_nxt;
                        occ_in       = occ_ff + CW'(1);
                        rsp_idx_in   = stk_top;
                     end
                  end
                  bpdq_pkg::CMD_POP: begin
                     if (occ_ff == '0) begin
                        rsp_status_in = bpdq_pkg::ST_EMPTY;
                     end else begin
                        head_in    = head_nxt;
                        occ_in     = occ_ff - CW'(1);
                        rsp_idx_in = ring_rd_data[IW-1:0];
                        rsp_len_in = ring_rd_data[IW +: LW];
                     end
                  end
                  bpdq_pkg::CMD_RELEASE: begin
                     if (bidx_bad || stk_count == DEPTH_C) begin
                        rsp_status_in = bpdq_pkg::ST_BAD_REL;
                     end else begin
                        stk_ctl.put = 1'b1;
                     end
                  end
                  default: begin
                     rsp_status_in = bpdq_pkg::ST_OK;
                  end
               endcase
               rsp_occ_in = occ_in;
            end
         end
         S_FLUSH: begin
            // Return the index read last cycle, drop it and flag an error if the stack is full
            if (pend_ff) begin
               stk_ctl.put = 1'b1;
               if (stk_count == DEPTH_C) begin
                  bad_in = 1'b1;
               end
            end
            pend_in = 1'b0;
            if (occ_ff != '0) begin
               ring_rd_en = 1'b1;
               head_in    = head_nxt;
               occ_in     = occ_ff - CW'(1);
               pend_in    = 1'b1;
            end else if (!pend_ff && out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = bad_ff ? bpdq_pkg::ST_BAD_REL : bpdq_pkg::ST_OK;
               rsp_idx_in    = '0;
               rsp_len_in    = '0;
               rsp_occ_in    = '0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state and registered response
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         max_len_ff   <= LW'(2048);
         pend_ff      <= 1'b0;
         bad_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         max_len_ff   <= max_len_in;
         pend_ff      <= pend_in;
         bad_ff       <= bad_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      len_ff        <= len_in;
      bidx_ff       <= bidx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.status         = rsp_status_ff;
   assign rsp.granted_index  = bpdq_pkg::IDX_W'(rsp_idx_ff);
   assign rsp.granted_length = rsp_len_ff;
   assign rsp.queued_count   = bpdq_pkg::CNT_W'(rsp_occ_ff);
   assign rsp.is_full        = (rsp_occ_ff == DEPTH_C);
   assign rsp.is_empty       = (rsp_occ_ff == '0);

endmodule

`default_nettype wire

// File: sv/buffer_pool_descriptor_queue_core.sv
// Buffer pool descriptor queue: free index stack plus descriptor ring, one request at a time.
// Push, pop and release go through a registered memory read, then commit and load the
// response register once it is free.
// Flush walks the ring and returns each queued buffer index to the free stack, then responds.
// A new request is taken only once the current one has loaded its response.
// Synchronous reset: queue empty, all buffers free, max_length 2048; no clearing pass.
`default_nettype none

module buffer_pool_descriptor_queue_core #(
   parameter int QUEUE_DEPTH = 64
) (
   input  wire logic  clock,
   input  wire logic  reset,
   bpdq_req_if.sink   req,
   bpdq_rsp_if.source rsp,
   bpdq_csr_if.sink   csr
);

   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int RW = bpdq_pkg::LEN_W + IW;

   bpdq_pkg::stk_ctl_type stk_ctl;
   logic [IW-1:0]         stk_put_data;
   logic [IW-1:0]         stk_top;
   logic [CW-1:0]         stk_count;
   logic                  ring_rd_en;
   logic [IW-1:0]         ring_rd_addr;
   logic [RW-1:0]         ring_rd_data;
   logic                  ring_wr_en;
   logic [IW-1:0]         ring_wr_addr;
   logic [RW-1:0]         ring_wr_data;

   bpdq_free_stack #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_free_stack (
      .clock    (clock),
      .reset    (reset),
      .ctl      (stk_ctl),
      .put_data (stk_put_data),
      .top_data (stk_top),
      .count    (stk_count)
   );

   // Descriptor ring: length above buffer index
   bpdq_ram #(
      .WIDTH (RW),
      .DEPTH (QUEUE_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_wr_en),
      .wr_addr (ring_wr_addr),
      .wr_data (ring_wr_data),
      .rd_en   (ring_rd_en),
      .rd_addr (ring_rd_addr),
      .rd_data (ring_rd_data)
   );

   bpdq_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req          (req),
      .rsp          (rsp),
      .csr          (csr),
      .stk_ctl      (stk_ctl),
      .stk_put_data (stk_put_data),
      .stk_top      (stk_top),
      .stk_count    (stk_count),
      .ring_rd_en   (ring_rd_en),
      .ring_rd_addr (ring_rd_addr),
      .ring_rd_data (ring_rd_data),
      .ring_wr_en   (ring_wr_en),
      .ring_wr_addr (ring_wr_addr),
      .ring_wr_data (ring_wr_data)
   );

endmodule

`default_nettype wire
